### rtl/lsb_first_bit_packer_core_defines.svh
// assertion macros for the lsb-first bit packer checker
// needs clk and rst_n in the scope where a macro is used
`ifndef LSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH
`define LSB_FIRST_BIT_PACKER_CORE_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lbp_pkg.sv
// shared types, constants and helpers for the lsb-first bit packer
// no dependencies
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 16;
    localparam int NBITS_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int BIT_OFF_W   = 3;
    localparam int MAX_BEATS   = 4;
    localparam int BEAT_SEL_W  = 2;
    localparam int WORD_W      = VALUE_BITS + BYTE_W;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_PUT     = 2'd0,
        REQ_REPORT  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } lbp_req_t;

    // stream position state
    typedef struct packed {
        logic [BYTE_W-1:0]    partial;
        logic [BIT_OFF_W-1:0] bit_off;
        logic [CAP_BITS-1:0]  byte_off;
    } lbp_state_t;

    // result of one item, shown as one to four beats
    typedef struct packed {
        logic [MAX_BEATS-1:0][BYTE_W-1:0] bytes;
        logic [BEAT_SEL_W-1:0]            last_sel;
        logic                             byte_valid;
        logic [CAP_BITS-1:0]              first_index;
        logic [CAP_BITS-1:0]              bytes_used;
        logic                             ok;
    } lbp_result_t;

    // full bytes plus one for a partial byte, saturated
    function automatic logic [CAP_BITS-1:0] used_count(
        input logic [CAP_BITS-1:0]  byte_off,
        input logic [BIT_OFF_W-1:0] bit_off
    );
        logic [CAP_BITS:0] sum;
        sum = {1'b0, byte_off} + {{CAP_BITS{1'b0}}, (bit_off != '0)};
        return sum[CAP_BITS] ? {CAP_BITS{1'b1}} : sum[CAP_BITS-1:0];
    endfunction

endpackage

### rtl/lbp_pack_calc.sv
// combinational packing step: next stream state and the result of one item
// depends on lbp_pkg
`timescale 1ns / 1ps

module lbp_pack_calc
    import lbp_pkg::*;
(
    input  lbp_req_t              req,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [NBITS_W-1:0]    nbits,
    input  logic [CAP_BITS-1:0]   capacity,
    input  lbp_state_t            cur,
    output lbp_state_t            nxt,
    output lbp_result_t           res
);

    logic [CAP_BITS-1:0]   room;
    logic [2:0]            room_cl;
    logic [NBITS_W-1:0]    avail;
    logic [NBITS_W-1:0]    nb_cl;
    logic [NBITS_W-1:0]    n_put;
    logic [VALUE_BITS-1:0] val_m;
    logic [WORD_W-1:0]     word;
    logic [WORD_W-1:0]     rest;
    logic [NBITS_W-1:0]    total;
    logic [2:0]            cnt;
    logic [2:0]            cnt_m1;
    lbp_state_t            put_st;

    // bits that still fit before the capacity, clamped past one full value
    always_comb
    begin
        room    = (cur.byte_off >= capacity) ? '0 : capacity - cur.byte_off;
        room_cl = (room >= CAP_BITS'(5)) ? 3'd5 : room[2:0];
        avail   = (room == '0) ? '0
                : {room_cl, 3'b000} - {{(NBITS_W-BIT_OFF_W){1'b0}}, cur.bit_off};
        nb_cl   = (nbits > NBITS_W'(VALUE_BITS)) ? NBITS_W'(VALUE_BITS) : nbits;
        n_put   = (nb_cl < avail) ? nb_cl : avail;
    end

    // merge the new bits above the partial byte
    always_comb
    begin
        val_m  = value & ~({VALUE_BITS{1'b1}} << n_put);
        word   = ({{BYTE_W{1'b0}}, val_m} << cur.bit_off)
               | {{VALUE_BITS{1'b0}}, cur.partial};
        total  = {{(NBITS_W-BIT_OFF_W){1'b0}}, cur.bit_off} + n_put;
        cnt    = total[NBITS_W-1:BIT_OFF_W];
        cnt_m1 = cnt - 3'd1;
        rest   = word >> {cnt, 3'b000};
        put_st.partial  = rest[BYTE_W-1:0];
        put_st.bit_off  = total[BIT_OFF_W-1:0];
        put_st.byte_off = cur.byte_off + {{(CAP_BITS-3){1'b0}}, cnt};
    end

    // select by request kind
    always_comb
    begin
        nxt = cur;
        res = '0;
        res.ok = 1'b1;
        unique case (req)
            REQ_PUT:
            begin
                nxt            = put_st;
                res.ok         = (n_put == nb_cl);
                res.bytes_used = used_count(put_st.byte_off, put_st.bit_off);
                if (cnt != '0)
                begin
                    res.bytes       = word[MAX_BEATS*BYTE_W-1:0];
                    res.byte_valid  = 1'b1;
                    res.first_index = cur.byte_off;
                    res.last_sel    = cnt_m1[BEAT_SEL_W-1:0];
                end
            end
            REQ_REPORT:
            begin
                res.byte_valid  = (cur.bit_off != '0);
                res.bytes[0]    = (cur.bit_off != '0) ? cur.partial : '0;
                res.first_index = cur.byte_off;
                res.bytes_used  = used_count(cur.byte_off, cur.bit_off);
            end
            REQ_RESTART:
            begin
                nxt = '0;
            end
            REQ_NONE:
            begin
                res.bytes_used = used_count(cur.byte_off, cur.bit_off);
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/lsb_first_bit_packer_core.sv
// lsb-first bit packer top level: input register, packing step, result register
// depends on lbp_pkg and lbp_pack_calc
`timescale 1ns / 1ps
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata value, nbits; tuser req_type
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata out_byte, byte_index, bytes_used;
//                                             tuser byte_valid, ok; tlast last
// cfg       in   cfg_valid/cfg_ready          cfg_data byte_capacity
//
// a put gives one to four beats, one per cycle from the result register while
// m_axis_tready is high; every other request gives one beat. an item waits in the
// input register and reaches the result register as the previous item's last beat
// leaves, so single-beat items flow at one per cycle while m_axis_tready is high.
// reset clears the stream position and sets the capacity to its maximum.
// a stalled output holds its beat while one more input beat waits behind it.

module lsb_first_bit_packer_core
    import lbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], nbits[37:32], zero pad
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // req_type[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0], byte_index[23:8],
                                                  // bytes_used[39:24]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // byte_valid[0], ok[1]
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_BITS-1:0]    cfg_data
);

    logic                  in_valid_reg;
    lbp_req_t              in_req_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic [NBITS_W-1:0]    in_nbits_reg;

    logic [CAP_BITS-1:0]   capacity_reg;
    lbp_state_t            state_reg;
    lbp_state_t            state_next;

    logic                  out_valid_reg;
    lbp_result_t           res_reg;
    lbp_result_t           res_next;
    logic [BEAT_SEL_W-1:0] ptr_reg;
    logic [CAP_BITS-1:0]   idx_reg;

    logic                  out_last;
    logic                  out_beat;
    logic                  out_free;
    logic                  move;

    // handshake control
    assign out_last      = (ptr_reg == res_reg.last_sel);
    assign out_beat      = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || (m_axis_tready && out_last);
    assign move          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= {CAP_BITS{1'b1}};
        else if (cfg_valid)
            capacity_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg   <= lbp_req_t'(s_axis_tuser);
            in_value_reg <= s_axis_tdata[VALUE_BITS-1:0];
            in_nbits_reg <= s_axis_tdata[VALUE_BITS+NBITS_W-1:VALUE_BITS];
        end
    end

    // packing step
    lbp_pack_calc u_calc (
        .req      (in_req_reg),
        .value    (in_value_reg),
        .nbits    (in_nbits_reg),
        .capacity (capacity_reg),
        .cur      (state_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    // stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (move)
            state_reg <= state_next;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
            ptr_reg       <= '0;
        end
        else if (out_beat)
        begin
            if (out_last)
                out_valid_reg <= 1'b0;
            else
                ptr_reg <= ptr_reg + BEAT_SEL_W'(1);
        end
    end

    // result payload and running byte index
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            res_reg <= res_next;
            idx_reg <= res_next.first_index;
        end
        else if (out_beat && !out_last)
        begin
            idx_reg <= idx_reg + CAP_BITS'(1);
        end
    end

    // output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_reg.bytes_used, idx_reg, res_reg.bytes[ptr_reg]};
    assign m_axis_tuser  = {res_reg.ok, res_reg.byte_valid};
    assign m_axis_tlast  = out_last;

endmodule

### rtl/lbp_checker.sv
// port-level checker for the lsb-first bit packer, bound to the top level
// depends on lbp_pkg and lsb_first_bit_packer_core_defines.svh
`timescale 1ns / 1ps
`include "lsb_first_bit_packer_core_defines.svh"

module lbp_checker
    import lbp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a stalled beat holds
    `LBP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output beat changed")

    // an empty beat carries a zero byte
    `LBP_ASSERT_SAME(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[7:0] == 8'd0, "empty beat with nonzero byte")

    // beats before the last carry bytes
    `LBP_ASSERT_SAME(a_mid_valid, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0], "non-final beat without a byte")

    // byte index steps by one within a burst
    `LBP_ASSERT_NEXT(a_index_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[23:8] == $past(m_axis_tdata[23:8]) + 16'd1), "byte index did not advance")

    // bytes used and ok stay the same within a burst
    `LBP_ASSERT_NEXT(a_burst_const, m_axis_tvalid && m_axis_tready && !m_axis_tlast, (m_axis_tdata[39:24] == $past(m_axis_tdata[39:24])) && (m_axis_tuser[1] == $past(m_axis_tuser[1])), "burst summary changed")

endmodule

bind lsb_first_bit_packer_core lbp_checker u_lbp_checker (.*);

### tb/sv/tb_top.sv
// self-checking testbench for lsb_first_bit_packer_core: directed and random requests
// depends on lbp_pkg and the packer rtl; a scoreboard class predicts every output beat
`timescale 1ns / 1ps

module tb_top;
    import lbp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 18;
    localparam int DRAIN_CYCLES = 8;

    // one output beat as seen on m_axis
    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] byte_index;
        logic [15:0] bytes_used;
        logic        ok;
        logic        last;
    } packer_beat_t;

    // predicts the beats of every accepted request and checks them in order
    class packer_scoreboard;
        packer_beat_t pending_beats[$];
        logic [7:0]   partial;
        logic [2:0]   bit_off;
        logic [15:0]  byte_off;
        logic [15:0]  capacity;
        int unsigned  error_count;
        int unsigned  beats_seen;

        function new();
            partial     = '0;
            bit_off     = '0;
            byte_off    = '0;
            capacity    = 16'hFFFF;
            error_count = 0;
            beats_seen  = 0;
        endfunction

        function void set_capacity(logic [15:0] cap);
            capacity = cap;
        endfunction

        // full bytes plus a partial one, held at the field maximum
        function logic [15:0] used_bytes();
            if (bit_off == 3'd0)
                return byte_off;
            if (byte_off == 16'hFFFF)
                return 16'hFFFF;
            return byte_off + 16'd1;
        endfunction

        function void push_beat(logic [7:0] data, logic valid, logic [15:0] index,
                                logic [15:0] used, logic ok_bit, logic last_bit);
            packer_beat_t beat;
            beat.out_byte   = data;
            beat.byte_valid = valid;
            beat.byte_index = index;
            beat.bytes_used = used;
            beat.ok         = ok_bit;
            beat.last       = last_bit;
            pending_beats.push_back(beat);
        endfunction

        function void note_request(lbp_req_t req, logic [31:0] value, logic [5:0] nbits);
            int          n;
            logic        ok_bit;
            logic [7:0]  done_byte[$];
            logic [15:0] done_pos[$];
            case (req)
                REQ_REPORT:
                    push_beat((bit_off != 3'd0) ? partial : 8'd0, bit_off != 3'd0,
                              byte_off, used_bytes(), 1'b1, 1'b1);
                REQ_RESTART:
                begin
                    partial  = '0;
                    bit_off  = '0;
                    byte_off = '0;
                    push_beat(8'd0, 1'b0, 16'd0, 16'd0, 1'b1, 1'b1);
                end
                REQ_NONE:
                    push_beat(8'd0, 1'b0, 16'd0, used_bytes(), 1'b1, 1'b1);
                default:
                begin
                    // put: bits go in lsb first, stop at the first bit past capacity
                    n      = (nbits > 6'd32) ? 32 : int'(nbits);
                    ok_bit = 1'b1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (byte_off >= capacity)
                        begin
                            ok_bit = 1'b0;
                            break;
                        end
                        partial[bit_off] = value[i];
                        if (bit_off == 3'd7)
                        begin
                            done_byte.push_back(partial);
                            done_pos.push_back(byte_off);
                            partial  = '0;
                            byte_off = byte_off + 16'd1;
                        end
                        bit_off = bit_off + 3'd1;
                    end
                    if (done_byte.size() == 0)
                        push_beat(8'd0, 1'b0, 16'd0, used_bytes(), ok_bit, 1'b1);
                    for (int k = 0; k < done_byte.size(); k++)
                        push_beat(done_byte[k], 1'b1, done_pos[k], used_bytes(), ok_bit,
                                  k == done_byte.size() - 1);
                end
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH beat %0d: %s", beats_seen, what);
            error_count++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, want %0h", name, got, want));
        endtask

        task check_beat(packer_beat_t got);
            packer_beat_t want;
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                report("output beat with nothing pending");
                return;
            end
            want = pending_beats.pop_front();
            compare_field("out_byte", got.out_byte, want.out_byte);
            compare_field("byte_valid", got.byte_valid, want.byte_valid);
            compare_field("byte_index", got.byte_index, want.byte_index);
            compare_field("bytes_used", got.bytes_used, want.bytes_used);
            compare_field("ok", got.ok, want.ok);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value[31:0], nbits[37:32], zero pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // req_type[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // out_byte[7:0], byte_index[23:8],
                                            // bytes_used[39:24]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // byte_valid[0], ok[1]
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CAP_BITS-1:0]    cfg_data;

    packer_scoreboard sb;
    bit               send_gaps;
    bit               recv_gaps;
    bit               hold_active;
    int unsigned      cycle_count;

    lsb_first_bit_packer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // output side: random stalls, long hold-off, check each accepted beat
    initial
    begin
        packer_beat_t got;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = !hold_active && !(recv_gaps && $urandom_range(0, 99) < IDLE_PCT);
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_byte   = m_axis_tdata[7:0];
                got.byte_index = m_axis_tdata[23:8];
                got.bytes_used = m_axis_tdata[39:24];
                got.byte_valid = m_axis_tuser[0];
                got.ok         = m_axis_tuser[1];
                got.last       = m_axis_tlast;
                sb.check_beat(got);
            end
        end
    end

    // offer one request beat and wait for it to be taken
    task automatic send_item(input lbp_req_t req, input logic [31:0] value,
                             input logic [5:0] nbits);
        @(negedge clk);
        while (send_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, nbits, value};
        s_axis_tuser  = req;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(req, value, nbits);
    endtask

    // drop valid, then wait for every pending beat
    task automatic finish_burst();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = cap;
        do @(posedge clk); while (!cfg_ready);
        sb.set_capacity(cap);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly puts, some reports and restarts, now and then the unused kind
    task automatic run_random(input int count);
        int          pick;
        lbp_req_t    req;
        logic [5:0]  nbits;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                req = REQ_RESTART;
            else if (pick < 18)
                req = REQ_REPORT;
            else if (pick < 22)
                req = REQ_NONE;
            else
                req = REQ_PUT;
            if ($urandom_range(0, 9) == 0)
                nbits = 6'($urandom_range(33, 63));
            else
                nbits = 6'($urandom_range(0, 32));
            send_item(req, $urandom, nbits);
        end
        finish_burst();
    endtask

    // main sequence
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PUT;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_active   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty report, zero bits, full words, clamping, partial bytes
        send_item(REQ_REPORT, 32'h0, 6'd0);
        send_item(REQ_PUT, 32'hFFFF_FFFF, 6'd0);
        send_item(REQ_PUT, 32'hFFFF_FFFF, 6'd32);
        send_item(REQ_PUT, 32'h0000_0005, 6'd3);
        send_item(REQ_REPORT, 32'hDEAD_BEEF, 6'd63);
        send_item(REQ_PUT, 32'h8000_0001, 6'd63);
        send_item(REQ_NONE, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_PUT, 32'h1234_5678, 6'd33);
        send_item(REQ_PUT, 32'h0, 6'd1);
        send_item(REQ_RESTART, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_REPORT, 32'h0, 6'd0);
        send_item(REQ_PUT, 32'h0000_00A5, 6'd8);
        finish_burst();

        // zero capacity: every put fails at once
        write_capacity(16'd0);
        send_item(REQ_PUT, 32'h0000_00FF, 6'd8);
        send_item(REQ_REPORT, 32'h0, 6'd0);
        finish_burst();

        // capacity of one byte: one byte out, then overflow in the same put
        write_capacity(16'd1);
        send_item(REQ_RESTART, 32'h0, 6'd0);
        send_item(REQ_PUT, 32'h0000_0FFF, 6'd12);
        send_item(REQ_REPORT, 32'h0, 6'd0);
        finish_burst();

        // capacity lowered below the current position
        write_capacity(16'hFFFF);
        send_item(REQ_PUT, 32'hCAFE_F00D, 6'd32);
        send_item(REQ_PUT, 32'h0F0F_0F0F, 6'd32);
        finish_burst();
        write_capacity(16'd2);
        send_item(REQ_PUT, 32'h0000_0003, 6'd4);
        send_item(REQ_REPORT, 32'h0, 6'd0);
        send_item(REQ_RESTART, 32'h0, 6'd0);
        send_item(REQ_PUT, 32'h0000_BEEF, 6'd16);
        finish_burst();

        // random phases over several capacities
        write_capacity(16'hFFFF);
        run_random(70);

        write_capacity(16'($urandom_range(0, 48)));
        run_random(60);

        // no idling anywhere, receiver held off at the start so the input backs up
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        write_capacity(16'hFFFF);
        fork
            begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
        join_none
        run_random(60);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;

        write_capacity(16'($urandom_range(0, 65535)));
        run_random(60);

        write_capacity(16'd3);
        run_random(60);

        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
